// ===== rtl/core/dtp_pkg.sv =====
// Shared types, character codes and calendar helpers for the timestamp text parser.
`default_nettype none
package dtp_pkg;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_T     = 8'h54;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [4:0] POS_DASH0  = 5'd4;
	localparam logic [4:0] POS_DASH1  = 5'd7;
	localparam logic [4:0] POS_SEP    = 5'd10;
	localparam logic [4:0] POS_COLON0 = 5'd13;
	localparam logic [4:0] POS_COLON1 = 5'd16;
	localparam logic [4:0] POS_YEAR_LO = 5'd2;
	localparam logic [4:0] TEXT_LEN   = 5'd19;
	localparam logic [4:0] POS_SAT    = 5'd20;

	localparam logic [13:0] YEAR_MIN  = 14'd2000;
	localparam logic [6:0]  HOUR_LIM  = 7'd24;
	localparam logic [6:0]  MIN_LIM   = 7'd60;

	typedef struct packed {
		logic [7:0] char_code;
	} in_word_t;

	typedef struct packed {
		logic        ok;
		logic [13:0] year_value;
		logic [6:0]  month_value;
		logic [6:0]  day_value;
		logic [6:0]  hour_value;
		logic [6:0]  minute_value;
		logic [6:0]  second_value;
	} out_word_t;

	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  year_hi;
		logic [6:0]  year_lo;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} fields_t;

	function automatic logic [4:0] days_in_month(input logic [6:0] month, input logic leap);
		logic [4:0] days;
		begin
			unique case (month)
				7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: days = 5'd31;
				7'd4, 7'd6, 7'd9, 7'd11:                     days = 5'd30;
				7'd2:    days = leap ? 5'd29 : 5'd28;
				default: days = 5'd0;
			endcase
			return days;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dtp_stream_if.sv =====
// Valid/ready stream channel carrying one payload word per handshake.
`default_nettype none
interface dtp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dtp_date_check.sv =====
// Calendar and clock range check on the gathered timestamp fields.
`default_nettype none
module dtp_date_check (
	input  wire dtp_pkg::fields_t fields,
	output logic                  ok
);
	import dtp_pkg::*;

	logic       leap;
	logic [4:0] days;

	// Year has exactly four digits here: century years use the upper pair
	always_comb begin
		if (fields.year_lo != 7'd0) begin
			leap = (fields.year_lo[1:0] == 2'd0);
		end else begin
			leap = (fields.year_hi[1:0] == 2'd0);
		end
	end

	assign days = days_in_month(fields.month, leap);

	assign ok = (fields.year >= YEAR_MIN) && (fields.month >= 7'd1) && (fields.month <= 7'd12)
		&& (fields.day >= 7'd1) && (fields.day <= {2'b00, days})
		&& (fields.hour < HOUR_LIM) && (fields.minute < MIN_LIM) && (fields.second < MIN_LIM);

endmodule
`default_nettype wire

// ===== rtl/core/datetime_text_parser.sv =====
// Top level: streaming YYYY-MM-DD hh:mm:ss text parser.
// A terminator word is registered in the input stage, then its result in the
// result register. Throughput: one character word per cycle unless a result waits;
// the input stage register can still take one new word while a result waits.
// Reset: arst_n clears position, error flag, accumulators and valid flags.
`default_nettype none
module datetime_text_parser (
	input  wire logic    clk,
	input  wire logic    arst_n,
	dtp_stream_if.sink   chars,
	dtp_stream_if.source results
);
	import dtp_pkg::*;

	logic            valid_s1;
	logic [7:0]      char_s1;
	logic            out_valid_q;
	out_word_t       out_q;

	logic [4:0]      pos_q;
	logic            err_q;
	fields_t         acc_q;
	fields_t         acc_d;
	logic            err_d;

	logic            advance;
	logic            fire;
	logic            is_term;
	logic            is_digit;
	logic [6:0]      digit;
	logic            fmt_ok;
	logic            date_ok;

	assign advance      = !out_valid_q || results.ready;
	assign chars.ready  = !valid_s1 || advance;
	assign fire         = valid_s1 && advance;
	assign is_term      = (char_s1 == CHAR_NUL);
	assign is_digit     = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE);
	assign digit        = 7'(char_s1 - CHAR_ZERO);
	assign fmt_ok       = (pos_q == TEXT_LEN) && !err_q;

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	dtp_date_check u_check (
		.fields (acc_q),
		.ok     (date_ok)
	);

	always_comb begin
		acc_d = acc_q;
		err_d = err_q;
		priority if (pos_q >= TEXT_LEN) begin
			err_d = 1'b1;
		end else if (pos_q == POS_DASH0 || pos_q == POS_DASH1) begin
			if (char_s1 != CHAR_DASH) err_d = 1'b1;
		end else if (pos_q == POS_SEP) begin
			if (char_s1 != CHAR_SPACE && char_s1 != CHAR_T) err_d = 1'b1;
		end else if (pos_q == POS_COLON0 || pos_q == POS_COLON1) begin
			if (char_s1 != CHAR_COLON) err_d = 1'b1;
		end else if (!is_digit) begin
			err_d = 1'b1;
		end else if (pos_q < POS_DASH0) begin
			acc_d.year = 14'(acc_q.year * 14'd10 + 14'(digit));
			if (pos_q < POS_YEAR_LO) begin
				acc_d.year_hi = 7'(acc_q.year_hi * 7'd10 + digit);
			end else begin
				acc_d.year_lo = 7'(acc_q.year_lo * 7'd10 + digit);
			end
		end else if (pos_q < POS_DASH1) begin
			acc_d.month = 7'(acc_q.month * 7'd10 + digit);
		end else if (pos_q < POS_SEP) begin
			acc_d.day = 7'(acc_q.day * 7'd10 + digit);
		end else if (pos_q < POS_COLON0) begin
			acc_d.hour = 7'(acc_q.hour * 7'd10 + digit);
		end else if (pos_q < POS_COLON1) begin
			acc_d.minute = 7'(acc_q.minute * 7'd10 + digit);
		end else begin
			acc_d.second = 7'(acc_q.second * 7'd10 + digit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.payload.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			err_q <= 1'b0;
			acc_q <= '0;
		end else if (fire) begin
			if (is_term) begin
				pos_q <= '0;
				err_q <= 1'b0;
				acc_q <= '0;
			end else begin
				err_q <= err_d;
				acc_q <= acc_d;
				if (pos_q < POS_SAT) pos_q <= pos_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && is_term;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_term) begin
			if (fmt_ok) begin
				out_q.ok           <= date_ok;
				out_q.year_value   <= acc_q.year;
				out_q.month_value  <= acc_q.month;
				out_q.day_value    <= acc_q.day;
				out_q.hour_value   <= acc_q.hour;
				out_q.minute_value <= acc_q.minute;
				out_q.second_value <= acc_q.second;
			end else begin
				out_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== verif/tb_datetime_text_parser.sv =====
// Testbench for datetime_text_parser: streams timestamp texts, predicts every parse result, checks each field.
module tb_datetime_text_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import dtp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASE_CHARS = 235;
	localparam int unsigned DRAIN_CYCLES = 10;

	typedef logic [7:0] text_t[$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dtp_stream_if #(.payload_t(in_word_t)) chars_if ();
	dtp_stream_if #(.payload_t(out_word_t)) results_if ();

	datetime_text_parser u_top (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_if),
		.results(results_if)
	);

	logic [7:0] char_backlog[$];
	out_word_t stamp_queue[$];
	int unsigned chars_queued = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic char_taken = 1'b0;
	logic hold_request = 1'b0;
	logic holding = 1'b0;
	int unsigned hold_left = 0;

	// parser shadow state
	logic [4:0]  text_pos;
	logic        format_broken;
	logic [13:0] year_sum;
	logic [6:0]  month_sum;
	logic [6:0]  day_sum;
	logic [6:0]  hour_sum;
	logic [6:0]  minute_sum;
	logic [6:0]  second_sum;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic clear_parser();
		text_pos = '0;
		format_broken = 1'b0;
		year_sum = '0;
		month_sum = '0;
		day_sum = '0;
		hour_sum = '0;
		minute_sum = '0;
		second_sum = '0;
	endtask

	task automatic parse_char(input logic [7:0] c);
		out_word_t stamp;
		logic [7:0] digit;
		logic leap;
		logic [6:0] max_day;
		digit = c - CHAR_ZERO;
		if (c == CHAR_NUL) begin
			stamp = '0;
			if (text_pos == TEXT_LEN && !format_broken) begin
				leap = (year_sum % 4 == 0 && year_sum % 100 != 0) || year_sum % 400 == 0;
				if (month_sum == 7'd2)
					max_day = leap ? 7'd29 : 7'd28;
				else if (month_sum == 7'd4 || month_sum == 7'd6 || month_sum == 7'd9 ||
						month_sum == 7'd11)
					max_day = 7'd30;
				else if (month_sum >= 7'd1 && month_sum <= 7'd12)
					max_day = 7'd31;
				else
					max_day = 7'd0;
				stamp.ok = year_sum >= YEAR_MIN && day_sum >= 7'd1 && day_sum <= max_day &&
					hour_sum < HOUR_LIM && minute_sum < MIN_LIM && second_sum < MIN_LIM;
				stamp.year_value = year_sum;
				stamp.month_value = month_sum;
				stamp.day_value = day_sum;
				stamp.hour_value = hour_sum;
				stamp.minute_value = minute_sum;
				stamp.second_value = second_sum;
			end
			stamp_queue.push_back(stamp);
			clear_parser();
		end else begin
			if (text_pos >= TEXT_LEN) begin
				format_broken = 1'b1;
			end else if (text_pos == POS_DASH0 || text_pos == POS_DASH1) begin
				if (c != CHAR_DASH) format_broken = 1'b1;
			end else if (text_pos == POS_SEP) begin
				if (c != CHAR_SPACE && c != CHAR_T) format_broken = 1'b1;
			end else if (text_pos == POS_COLON0 || text_pos == POS_COLON1) begin
				if (c != CHAR_COLON) format_broken = 1'b1;
			end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
				format_broken = 1'b1;
			end else if (text_pos < POS_DASH0) begin
				year_sum = 14'(year_sum * 10 + digit);
			end else if (text_pos < POS_DASH1) begin
				month_sum = 7'(month_sum * 10 + digit);
			end else if (text_pos < POS_SEP) begin
				day_sum = 7'(day_sum * 10 + digit);
			end else if (text_pos < POS_COLON0) begin
				hour_sum = 7'(hour_sum * 10 + digit);
			end else if (text_pos < POS_COLON1) begin
				minute_sum = 7'(minute_sum * 10 + digit);
			end else begin
				second_sum = 7'(second_sum * 10 + digit);
			end
			if (text_pos < POS_SAT) text_pos = text_pos + 5'd1;
		end
	endtask

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want,
			cycle_count);
		mismatch_count++;
	endtask

	function automatic text_t to_bytes(input string s);
		text_t t;
		for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
		return t;
	endfunction

	task automatic queue_text(input text_t t);
		foreach (t[i]) char_backlog.push_back(t[i]);
		char_backlog.push_back(CHAR_NUL);
		chars_queued += t.size() + 1;
	endtask

	function automatic int unsigned pick_field(input int unsigned lo, input int unsigned hi,
			input int unsigned top);
		if ($urandom_range(0, 99) < 85) return $urandom_range(lo, hi);
		return $urandom_range(0, top);
	endfunction

	task automatic queue_random_text();
		text_t t;
		int unsigned roll;
		int unsigned k;
		string sep;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			repeat ($urandom_range(0, 30)) t.push_back(8'($urandom_range(1, 255)));
		end else begin
			sep = $urandom_range(0, 1) ? " " : "T";
			t = to_bytes($sformatf("%04d-%02d-%02d%s%02d:%02d:%02d",
				pick_field(1998, 2104, 9999), pick_field(0, 13, 99), pick_field(0, 32, 99),
				sep, pick_field(0, 24, 99), pick_field(0, 60, 99), pick_field(0, 60, 99)));
			k = $urandom_range(0, 18);
			if (roll < 14)
				t[k] = 8'($urandom_range(0, 255));
			else if (roll < 19)
				while (t.size() > k) void'(t.pop_back());
			else if (roll < 25)
				repeat ($urandom_range(1, 16)) t.push_back(8'($urandom_range(1, 255)));
		end
		queue_text(t);
	endtask

	task automatic queue_random_phase();
		int unsigned start_count;
		start_count = chars_queued;
		while (chars_queued - start_count < PHASE_CHARS) queue_random_text();
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (char_backlog.size() != 0 || chars_if.valid || stamp_queue.size() != 0)
			@(negedge clk);
	endtask

	// word sender
	always @(negedge clk) begin
		if (chars_if.valid && !char_taken) begin
			chars_if.valid <= 1'b1;
		end else if (arst_n && char_backlog.size() != 0 &&
				$urandom_range(0, 99) >= send_idle_pct) begin
			chars_if.valid <= 1'b1;
			chars_if.payload <= char_backlog[0];
		end else begin
			chars_if.valid <= 1'b0;
			chars_if.payload <= 8'($urandom_range(0, 255));
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (!arst_n || holding)
			results_if.ready <= 1'b0;
		else
			results_if.ready <= $urandom_range(0, 99) >= recv_idle_pct;
	end

	always @(negedge clk) begin
		if (holding) begin
			if (hold_left == 0)
				holding <= 1'b0;
			else
				hold_left <= hold_left - 1;
		end else if (hold_request) begin
			holding <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end
	end

	// acceptance on both channels
	always @(posedge clk) begin
		out_word_t got;
		out_word_t want;
		char_taken = chars_if.valid && chars_if.ready;
		if (char_taken) begin
			parse_char(chars_if.payload.char_code);
			void'(char_backlog.pop_front());
		end
		if (results_if.valid && results_if.ready) begin
			got = results_if.payload;
			if (stamp_queue.size() == 0) begin
				flag_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = stamp_queue.pop_front();
				if (got.ok !== want.ok) flag_mismatch("ok", got.ok, want.ok);
				if (got.year_value !== want.year_value)
					flag_mismatch("year_value", got.year_value, want.year_value);
				if (got.month_value !== want.month_value)
					flag_mismatch("month_value", got.month_value, want.month_value);
				if (got.day_value !== want.day_value)
					flag_mismatch("day_value", got.day_value, want.day_value);
				if (got.hour_value !== want.hour_value)
					flag_mismatch("hour_value", got.hour_value, want.hour_value);
				if (got.minute_value !== want.minute_value)
					flag_mismatch("minute_value", got.minute_value, want.minute_value);
				if (got.second_value !== want.second_value)
					flag_mismatch("second_value", got.second_value, want.second_value);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_datetime_text_parser: done, errors");
			$finish;
		end
	end

	initial begin
		text_t t;
		clear_parser();
		chars_if.valid = 1'b0;
		chars_if.payload = '0;
		results_if.ready = 1'b0;
		send_idle_pct = 7;
		recv_idle_pct = 79;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_text(to_bytes("2000-01-01 00:00:00"));
		queue_text(to_bytes("9999-12-31T23:59:59"));
		queue_text(to_bytes("2024-02-29 12:30:45"));
		queue_text(to_bytes("2100-02-29 00:00:00"));
		queue_text(to_bytes("2000-02-29T00:00:00"));
		queue_text(to_bytes("2023-02-29 00:00:00"));
		queue_text(to_bytes("1999-12-31 23:59:59"));
		queue_text(to_bytes("2023-00-10 10:10:10"));
		queue_text(to_bytes("2023-13-10 10:10:10"));
		queue_text(to_bytes("2023-04-31 10:10:10"));
		queue_text(to_bytes("2023-05-00 10:10:10"));
		queue_text(to_bytes("2023-01-01 24:00:00"));
		queue_text(to_bytes("2023-01-01 23:60:00"));
		queue_text(to_bytes("2023-01-01 23:59:60"));
		queue_text(to_bytes("9999-99-99 99:99:99"));
		queue_text(to_bytes("2023/01-01 12:00:00"));
		queue_text(to_bytes("2023-01/01 12:00:00"));
		queue_text(to_bytes("2023-01-01t12:00:00"));
		queue_text(to_bytes("2023-01-01 12.00:00"));
		queue_text(to_bytes("2023-01-01 12:00;00"));
		queue_text(to_bytes("2/2:-01-01 12:00:00"));
		queue_text(to_bytes(""));
		queue_text(to_bytes("2023-01-01 12:00:0"));
		queue_text(to_bytes("2023-01-01 12:00:000"));
		t = to_bytes("2023-06-15 08:45:30");
		repeat (15) t.push_back(8'hFF);
		queue_text(t);

		queue_random_phase();
		wait_idle();

		send_idle_pct = 79;
		recv_idle_pct = 7;
		queue_random_phase();
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		queue_random_phase();
		wait (holding);
		hold_request = 1'b0;
		wait_idle();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("tb_datetime_text_parser: done, clean");
		else
			$display("tb_datetime_text_parser: done, errors");
		$finish;
	end
endmodule

// ===== datetime_text_parser.f =====
rtl/core/dtp_pkg.sv
rtl/core/dtp_stream_if.sv
rtl/core/dtp_date_check.sv
rtl/core/datetime_text_parser.sv
verif/tb_datetime_text_parser.sv
